### sv/maes_pkg.sv
// ----------------------------------------------------------------------------
// maes_pkg
// Shared types and byte transforms for the modified AES-128 block cipher.
// ----------------------------------------------------------------------------
package maes_pkg;

    localparam int NumRounds = 10;
    localparam int NumStages = NumRounds + 1;
    localparam int RegIdxWidth = 1;

    typedef enum logic [RegIdxWidth-1:0] {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } reg_idx_t;

    typedef enum logic {
        CMD_ENCRYPT = 1'b0,
        CMD_DECRYPT = 1'b1
    } cmd_t;

    typedef struct packed {
        logic        command;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } out_item_t;

    // per-stage control that travels with the block
    typedef struct packed {
        logic valid;
        logic decrypt;
    } stage_ctl_t;

    typedef logic [127:0] state_t;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        logic [7:0] r;
        r = {a[6:0], 1'b0};
        if (a[7]) r = r ^ 8'h1b;
        return r;
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc = acc ^ x;
            x = xtime(x);
        end
        return acc;
    endfunction

    function automatic logic [7:0] gf_inv(input logic [7:0] a);
        logic [7:0] r;
        logic [7:0] b;
        r = 8'h01;
        b = a;
        // exponent 254 = 11111110b
        for (int i = 0; i < 8; i++) begin
            if (i != 0) r = gf_mul(r, b);
            b = gf_mul(b, b);
        end
        return r;
    endfunction

    function automatic logic [7:0] rotl(input logic [7:0] x, input int n);
        logic [15:0] d;
        d = {x, x} << n;
        return d[15:8];
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] b;
        b = gf_inv(x);
        return b ^ rotl(b, 1) ^ rotl(b, 2) ^ rotl(b, 3) ^ rotl(b, 4) ^ 8'h63;
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] y);
        return gf_inv(rotl(y, 1) ^ rotl(y, 3) ^ rotl(y, 6) ^ 8'h05);
    endfunction

    // constant tables built at elaboration
    typedef logic [7:0] byte_tab_t [256];

    function automatic byte_tab_t build_fwd();
        byte_tab_t t;
        for (int i = 0; i < 256; i++) t[i] = sbox(xtime(8'(i)) ^ 8'h01);
        return t;
    endfunction

    function automatic byte_tab_t build_inv();
        byte_tab_t t;
        logic [7:0] u;
        for (int i = 0; i < 256; i++) begin
            u = inv_sbox(8'(i));
            if (!u[0]) t[i] = ((u ^ 8'h01 ^ 8'h1b) >> 1) | 8'h80;
            else t[i] = (u ^ 8'h01) >> 1;
        end
        return t;
    endfunction

    function automatic byte_tab_t build_sbox();
        byte_tab_t t;
        for (int i = 0; i < 256; i++) t[i] = sbox(8'(i));
        return t;
    endfunction

    localparam byte_tab_t FwdSub = build_fwd();
    localparam byte_tab_t InvSub = build_inv();
    localparam byte_tab_t AesSbox = build_sbox();

    // byte i of the state sits in bits 127-8i
    function automatic logic [7:0] get_byte(input state_t s, input int i);
        return s[127-8*i -: 8];
    endfunction

    function automatic state_t sub_bytes(input state_t s, input logic inv);
        state_t t;
        for (int i = 0; i < 16; i++)
            t[127-8*i -: 8] = inv ? InvSub[get_byte(s, i)] : FwdSub[get_byte(s, i)];
        return t;
    endfunction

    function automatic state_t shift_rows(input state_t s, input logic inv);
        state_t t;
        int src;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) begin
                src = inv ? ((c - r) & 3) : ((c + r) & 3);
                t[127-8*(4*c+r) -: 8] = get_byte(s, 4*src + r);
            end
        return t;
    endfunction

    function automatic state_t mix_columns(input state_t s, input logic inv);
        state_t t;
        logic [7:0] m [4];
        logic [7:0] acc;
        if (inv) begin
            m[0] = 8'ha5; m[1] = 8'h07; m[2] = 8'h1a; m[3] = 8'h73;
        end else begin
            m[0] = 8'h01; m[1] = 8'h04; m[2] = 8'h04; m[3] = 8'h05;
        end
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                acc = 8'h00;
                for (int k = 0; k < 4; k++)
                    acc = acc ^ gf_mul(get_byte(s, 4*c + k), m[(k - r) & 3]);
                t[127-8*(4*c+r) -: 8] = acc;
            end
        return t;
    endfunction

endpackage

### sv/modified_aes128_block_cipher.sv
// ----------------------------------------------------------------------------
// modified_aes128_block_cipher
// Pipelined modified AES-128 encrypt/decrypt with a key register port.
// ----------------------------------------------------------------------------
// One block enters per cycle while in_stall is low, via one register stage
// for the initial key add and ten round stages, each one round of byte
// substitution, row shift, column mix (not in the last encrypt or first
// decrypt round) and key add. The whole pipeline moves when the output is
// free, so throughput is one block per cycle. Reset or a key write rebuilds
// the round keys one per cycle, with cfg_ready low and in_stall high.
module modified_aes128_block_cipher
    import maes_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [RegIdxWidth-1:0] cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_item
);

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic        key_wr;
    logic        ks_busy;
    state_t      round_keys [NumStages];
    logic        advance;
    stage_ctl_t  ctl [NumStages];
    state_t      st  [NumStages];
    stage_ctl_t  ctl0_reg;
    state_t      st0_reg;

    assign key_wr = cfg_valid && cfg_ready;
    assign cfg_ready = !ks_busy;

    // key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg <= '0;
        end
        else if (key_wr)
        begin
            case (reg_idx_t'(cfg_index))
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LOW:  key_low_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    maes_keyexp u_keyexp (
        .clk        (clk),
        .rst_n      (rst_n),
        .key        ((reg_idx_t'(cfg_index) == REG_KEY_HIGH && key_wr) ?
                     {cfg_data, key_low_reg} :
                     (key_wr ? {key_high_reg, cfg_data} : {key_high_reg, key_low_reg})),
        .start      (key_wr),
        .round_keys (round_keys),
        .busy       (ks_busy)
    );

    // whole pipeline moves unless the output holds a result that is stalled
    assign advance = !(out_valid && out_stall);
    assign in_stall = !advance || ks_busy;

    // entry stage: initial key add
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) ctl0_reg <= '0;
        else if (advance)
        begin
            ctl0_reg.valid <= in_valid && !ks_busy;
            ctl0_reg.decrypt <= (in_item.command == CMD_DECRYPT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            st0_reg <= {in_item.block_high, in_item.block_low} ^
                       ((in_item.command == CMD_DECRYPT) ? round_keys[NumRounds] :
                        round_keys[0]);
    end

    assign ctl[0] = ctl0_reg;
    assign st[0] = st0_reg;

    // round stages
    for (genvar r = 1; r <= NumRounds; r++)
    begin : g_round
        maes_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .ctl_in    (ctl[r-1]),
            .state_in  (st[r-1]),
            .key_enc   (round_keys[r]),
            .key_dec   (round_keys[NumRounds - r]),
            .first     (r == 1),
            .last      (r == NumRounds),
            .ctl_out   (ctl[r]),
            .state_out (st[r])
        );
    end

    assign out_valid = ctl[NumRounds].valid;
    assign out_item.result_high = st[NumRounds][127:64];
    assign out_item.result_low = st[NumRounds][63:0];

endmodule

### sv/maes_keyexp.sv
// ----------------------------------------------------------------------------
// maes_keyexp
// Registered AES-128 key schedule, one round key per cycle after a key write.
// ----------------------------------------------------------------------------
module maes_keyexp
    import maes_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [127:0] key,
    input  logic         start,
    output state_t       round_keys [NumStages],
    output logic         busy
);

    state_t       rk_reg [NumStages];
    logic [3:0]   idx_reg;
    logic [3:0]   idx_next;
    logic [7:0]   rcon_reg;
    logic [7:0]   rcon_next;
    logic         busy_reg;
    logic         busy_next;
    state_t       key_next;

    // one expansion step from the previous round key
    always_comb
    begin
        logic [31:0] w [4];
        logic [31:0] t;
        state_t prev;
        prev = rk_reg[idx_reg - 4'd1];
        for (int j = 0; j < 4; j++) w[j] = prev[127-32*j -: 32];
        t = {AesSbox[w[3][23:16]] ^ rcon_reg, AesSbox[w[3][15:8]],
             AesSbox[w[3][7:0]], AesSbox[w[3][31:24]]};
        w[0] = w[0] ^ t;
        w[1] = w[1] ^ w[0];
        w[2] = w[2] ^ w[1];
        w[3] = w[3] ^ w[2];
        key_next = {w[0], w[1], w[2], w[3]};
        idx_next = idx_reg;
        rcon_next = rcon_reg;
        busy_next = busy_reg;
        if (start)
        begin
            idx_next = 4'd1;
            rcon_next = 8'h01;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rcon_next = xtime(rcon_reg);
            if (idx_reg == 4'(NumStages - 1)) busy_next = 1'b0;
            else idx_next = idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 4'd1;
            rcon_reg <= 8'h01;
            busy_reg <= 1'b1;
        end
        else
        begin
            idx_reg <= idx_next;
            rcon_reg <= rcon_next;
            busy_reg <= busy_next;
        end
    end

    // key storage, the zero key after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumStages; i++) rk_reg[i] <= '0;
        end
        else if (start) rk_reg[0] <= key;
        else if (busy_reg) rk_reg[idx_reg] <= key_next;
    end

    assign round_keys = rk_reg;
    assign busy = busy_reg;

endmodule

### sv/maes_round.sv
// ----------------------------------------------------------------------------
// maes_round
// One registered cipher round for either direction.
// ----------------------------------------------------------------------------
module maes_round
    import maes_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  stage_ctl_t ctl_in,
    input  state_t     state_in,
    input  state_t     key_enc,
    input  state_t     key_dec,
    input  logic       first,
    input  logic       last,
    output stage_ctl_t ctl_out,
    output state_t     state_out
);

    stage_ctl_t ctl_reg;
    state_t     state_reg;
    state_t     state_next;

    // encrypt: sub, shift, mix (not in last), then key
    // decrypt: inverse mix (not in first), inverse shift, inverse sub, key
    always_comb
    begin
        state_t s;
        if (!ctl_in.decrypt)
        begin
            s = shift_rows(sub_bytes(state_in, 1'b0), 1'b0);
            if (!last) s = mix_columns(s, 1'b0);
            state_next = s ^ key_enc;
        end
        else
        begin
            s = state_in;
            if (!first) s = mix_columns(s, 1'b1);
            s = sub_bytes(shift_rows(s, 1'b1), 1'b1);
            state_next = s ^ key_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) ctl_reg <= '0;
        else if (advance) ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (advance) state_reg <= state_next;
    end

    assign ctl_out = ctl_reg;
    assign state_out = state_reg;

endmodule

### bench/maes_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// maes_checker
// Watches the key, input and output channels of the modified AES-128 cipher,
// predicts each result from its own cipher model and compares in order.
// ----------------------------------------------------------------------------
module maes_checker
    import maes_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [RegIdxWidth-1:0] cfg_index,
    input  logic [63:0]            cfg_data,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  in_item_t               in_item,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  out_item_t              out_item,
    output int                     fail_count,
    output int                     pending
);

    typedef logic [7:0] blk_t [16];

    logic [7:0] s_tab [256];
    logic [7:0] fsub_tab [256];
    logic [7:0] isub_tab [256];
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    out_item_t cipher_expected [$];

    function automatic logic [7:0] dbl(input logic [7:0] a);
        return a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
    endfunction

    function automatic logic [7:0] fmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i]) acc ^= a;
            a = dbl(a);
        end
        return acc;
    endfunction

    // substitution tables, the inverse found by inverting the forward map
    initial
    begin
        logic [7:0] v;
        logic [7:0] b;
        for (int i = 0; i < 256; i++)
        begin
            v = 8'h01;
            for (int e = 0; e < 254; e++) v = fmul(v, 8'(i));
            if (i == 0) v = 8'h00;
            b = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]}
                ^ {v[3:0], v[7:4]} ^ 8'h63;
            s_tab[i] = b;
        end
        for (int i = 0; i < 256; i++)
        begin
            fsub_tab[i] = s_tab[dbl(8'(i)) ^ 8'h01];
            isub_tab[fsub_tab[i]] = 8'(i);
        end
    end

    function automatic void mix(ref blk_t st, input logic [7:0] m [4]);
        logic [7:0] col [4];
        logic [7:0] acc;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++) col[r] = st[4*c+r];
            for (int r = 0; r < 4; r++)
            begin
                acc = 8'h00;
                for (int k = 0; k < 4; k++) acc ^= fmul(col[k], m[(k - r) & 3]);
                st[4*c+r] = acc;
            end
        end
    endfunction

    function automatic void shift(ref blk_t st, input logic inv);
        blk_t t;
        int src;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
            begin
                src = inv ? ((c - r) & 3) : ((c + r) & 3);
                t[4*c+r] = st[4*src+r];
            end
        st = t;
    endfunction

    // encrypt or decrypt one block under the current key
    function automatic out_item_t cipher_block(input in_item_t it);
        logic [7:0] rk [176];
        logic [7:0] t [4];
        logic [7:0] f;
        logic [7:0] rcon;
        logic [7:0] fm [4];
        logic [7:0] im [4];
        logic [127:0] kv;
        logic [127:0] bv;
        blk_t st;
        out_item_t res;
        fm = '{8'h01, 8'h04, 8'h04, 8'h05};
        im = '{8'ha5, 8'h07, 8'h1a, 8'h73};
        kv = {key_hi, key_lo};
        bv = {it.block_high, it.block_low};
        rcon = 8'h01;
        for (int i = 0; i < 16; i++)
        begin
            rk[i] = kv[127-8*i -: 8];
            st[i] = bv[127-8*i -: 8];
        end
        for (int w = 4; w < 44; w++)
        begin
            for (int j = 0; j < 4; j++) t[j] = rk[4*(w-1)+j];
            if ((w & 3) == 0)
            begin
                f = t[0];
                t[0] = s_tab[t[1]] ^ rcon;
                t[1] = s_tab[t[2]];
                t[2] = s_tab[t[3]];
                t[3] = s_tab[f];
                rcon = dbl(rcon);
            end
            for (int j = 0; j < 4; j++) rk[4*w+j] = rk[4*(w-4)+j] ^ t[j];
        end
        if (cmd_t'(it.command) == CMD_ENCRYPT)
        begin
            for (int rnd = 0; rnd < 10; rnd++)
            begin
                for (int i = 0; i < 16; i++) st[i] = fsub_tab[st[i] ^ rk[16*rnd+i]];
                shift(st, 1'b0);
                if (rnd < 9) mix(st, fm);
            end
            for (int i = 0; i < 16; i++) st[i] ^= rk[160+i];
        end
        else
        begin
            for (int i = 0; i < 16; i++) st[i] ^= rk[160+i];
            for (int rnd = 9; rnd >= 0; rnd--)
            begin
                if (rnd < 9) mix(st, im);
                shift(st, 1'b1);
                for (int i = 0; i < 16; i++) st[i] = isub_tab[st[i]] ^ rk[16*rnd+i];
            end
        end
        for (int i = 0; i < 16; i++) bv[127-8*i -: 8] = st[i];
        res.result_high = bv[127:64];
        res.result_low = bv[63:0];
        return res;
    endfunction

    // key writes, accepted items and results
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t exp_item;
        int errs;
        errs = 0;
        if (!rst_n)
        begin
            key_hi <= '0;
            key_lo <= '0;
            fail_count <= 0;
            pending <= 0;
            cipher_expected.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (reg_idx_t'(cfg_index) == REG_KEY_HIGH) key_hi <= cfg_data;
                else if (reg_idx_t'(cfg_index) == REG_KEY_LOW) key_lo <= cfg_data;
            end
            if (in_valid && !in_stall) cipher_expected.push_back(cipher_block(in_item));
            if (out_valid && !out_stall)
            begin
                if (cipher_expected.size() == 0)
                begin
                    $error("result with no item outstanding: %h %h",
                           out_item.result_high, out_item.result_low);
                    errs++;
                end
                else
                begin
                    exp_item = cipher_expected.pop_front();
                    if (exp_item.result_high !== out_item.result_high)
                    begin
                        $error("result_high expected %h actual %h",
                               exp_item.result_high, out_item.result_high);
                        errs++;
                    end
                    if (exp_item.result_low !== out_item.result_low)
                    begin
                        $error("result_low expected %h actual %h",
                               exp_item.result_low, out_item.result_low);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending <= cipher_expected.size();
        end
    end

endmodule

### bench/tb_modified_aes128_block_cipher.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modified_aes128_block_cipher
// Drives keys and blocks into the modified AES-128 cipher with random gaps
// and output stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_modified_aes128_block_cipher;
    import maes_pkg::*;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [RegIdxWidth-1:0] cfg_index = '0;
    logic [63:0]            cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    in_item_t               in_item = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_item_t              out_item;
    int                     fail_count;
    int                     pending;
    bit                     quiet_phase = 1'b0;

    modified_aes128_block_cipher u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    maes_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #10 clk = ~clk;

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int p;
        if (quiet_phase) return 0;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(3, 1);
        return $urandom_range(30, 5);
    endfunction

    // receiver stalls in bursts
    always @(posedge clk)
    begin
        int run;
        if (run > 0) run--;
        else if (!quiet_phase && $urandom_range(99) < 20) run = gap_len();
        out_stall <= (run > 0);
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic write_key(input reg_idx_t idx, input logic [63:0] value);
        while (pending != 0) @(posedge clk);
        repeat (15) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // present one block and hold it until taken
    task automatic send_block(input cmd_t cmd, input logic [63:0] hi, input logic [63:0] lo);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= '{command: cmd, block_high: hi, block_low: lo};
        do @(posedge clk); while (in_stall);
    endtask

    task automatic end_burst();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_blocks(input int n);
        for (int i = 0; i < n; i++)
        begin
            if (i % 60 == 0) quiet_phase = ($urandom_range(3) == 0);
            send_block(cmd_t'($urandom_range(1)), rand64(), rand64());
        end
        quiet_phase = 1'b0;
        end_burst();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed blocks under the reset key of zero
        send_block(CMD_ENCRYPT, '0, '0);
        send_block(CMD_DECRYPT, '0, '0);
        send_block(CMD_ENCRYPT, '1, '1);
        send_block(CMD_DECRYPT, '1, '1);
        send_block(CMD_ENCRYPT, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
        send_block(CMD_DECRYPT, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
        send_block(CMD_ENCRYPT, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
        send_block(CMD_DECRYPT, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
        end_burst();

        // largest key
        write_key(REG_KEY_HIGH, '1);
        write_key(REG_KEY_LOW, '1);
        send_block(CMD_ENCRYPT, '0, '0);
        send_block(CMD_DECRYPT, '0, '0);
        send_block(CMD_ENCRYPT, '1, '1);
        send_block(CMD_DECRYPT, '1, '1);
        end_burst();
        random_blocks(100);

        // single bits at both ends of the key
        write_key(REG_KEY_HIGH, 64'h8000_0000_0000_0000);
        write_key(REG_KEY_LOW, 64'h0000_0000_0000_0001);
        random_blocks(100);

        // random keys, one half at a time too
        for (int k = 0; k < 5; k++)
        begin
            write_key(REG_KEY_HIGH, rand64());
            if (k != 2) write_key(REG_KEY_LOW, rand64());
            random_blocks(200);
        end

        // back to the zero key
        write_key(REG_KEY_HIGH, '0);
        write_key(REG_KEY_LOW, '0);
        random_blocks(150);

        while (pending != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

### modified_aes128_block_cipher.f
sv/maes_pkg.sv
sv/maes_keyexp.sv
sv/maes_round.sv
sv/modified_aes128_block_cipher.sv
bench/maes_checker.sv
bench/tb_modified_aes128_block_cipher.sv
